FILE: hdl/nqb_pkg.sv
// ----------------------------------------------------------------------------
// nqb_pkg
// Shared constants for the N-queens backtracking solver and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nqb_pkg;

   // Largest board the search storage is sized for.
   localparam int MAX_SIZE_DEFAULT = 16;

   // Field widths on the stream ports.
   localparam int BOARD_SIZE_W = 5;
   localparam int ROW_INDEX_W  = 4;
   localparam int QUEEN_COL_W  = 4;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 8;

endpackage

`default_nettype wire

FILE: hdl/n_queens_backtrack_solver.sv
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver
// Depth-first N-queens search with one shared conflict checker and a small
// placement memory.
// ----------------------------------------------------------------------------
// A request beat carries a board size (sizes above MAX_SIZE are clamped). The
// block searches for the first placement with the row 0 queen in column 0,
// then sends one response beat per row (tuser = 1, tlast on the final row),
// or one beat with tuser = 0, zero data and tlast set when no placement exists.
// Only one request is handled at a time: req_tready stays low from acceptance
// until the final response beat is taken. Search time is data dependent: each
// test of a candidate column against the queens above it walks the earlier
// rows in turn, because the single comparator reads one placed queen per cycle
// from the placement memory.
`default_nettype none

module n_queens_backtrack_solver
   import nqb_pkg::*;
#(
   parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: [4:0] board_size, [7:5] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // rsp_tdata: [3:0] row_index, [7:4] queen_column
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // rsp_tuser: [0] found
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready
);

   localparam int CNT_W = $clog2(MAX_SIZE + 1);
   localparam int COL_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int CMP_W = CNT_W + 1;
   localparam logic [5:0] MAX_SIZE6 = 6'(MAX_SIZE);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_TRY      = 7'b0000010,
      ST_CHECK    = 7'b0000100,
      ST_BACK     = 7'b0001000,
      ST_OUT_RD   = 7'b0010000,
      ST_OUT_LOAD = 7'b0100000,
      ST_OUT_WAIT = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       row_ff, row_in;
   logic [CNT_W-1:0]       cand_ff, cand_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       out_row_ff, out_row_in;

   logic [COL_W-1:0]       placed_column_ff [MAX_SIZE];
   logic [COL_W-1:0]       rd_data_ff;
   logic [COL_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [COL_W-1:0]       wr_addr;
   logic [COL_W-1:0]       wr_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [ROW_INDEX_W-1:0] rsp_row_ff, rsp_row_in;
   logic [QUEEN_COL_W-1:0] rsp_col_ff, rsp_col_in;

   logic [5:0]             size_sat;
   logic                   req_fire;
   logic                   rsp_fire;
   logic [CMP_W-1:0]       p_w, c_w, d_w;
   logic                   conflict;
   logic [CNT_W+3:0]       row_ext;
   logic [COL_W+3:0]       col_ext;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_valid_ff && rsp_tready;

   assign size_sat = ({1'b0, req_tdata[BOARD_SIZE_W-1:0]} > MAX_SIZE6)
                     ? MAX_SIZE6 : {1'b0, req_tdata[BOARD_SIZE_W-1:0]};

   // Shared conflict check: the queen read from memory against the candidate.
   assign p_w = CMP_W'(rd_data_ff);
   assign c_w = CMP_W'(cand_ff);
   assign d_w = CMP_W'(row_ff - idx_ff);
   assign conflict = (p_w == c_w) || (p_w + d_w == c_w) || (c_w + d_w == p_w);

   assign row_ext = {4'b0, out_row_ff};
   assign col_ext = {4'b0, rd_data_ff};

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      row_in       = row_ff;
      cand_in      = cand_ff;
      idx_in       = idx_ff;
      out_row_in   = out_row_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               n_in = size_sat[CNT_W-1:0];
               if (size_sat == 6'd0) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_last_in  = 1'b1;
                  rsp_row_in   = '0;
                  rsp_col_in   = '0;
                  state_in     = ST_OUT_WAIT;
               end else begin
                  wr_en    = 1'b1;
                  row_in   = CNT_W'(1);
                  cand_in  = '0;
                  state_in = ST_TRY;
               end
            end
         end
         ST_TRY: begin
            if (row_ff == n_ff) begin
               out_row_in = '0;
               state_in   = ST_OUT_RD;
            end else if (cand_ff >= n_ff) begin
               row_in  = row_ff - CNT_W'(1);
               rd_addr = COL_W'(row_ff - CNT_W'(1));
               if (row_ff == CNT_W'(1)) begin
                  // Row 1 ran out of columns: the whole tree is exhausted.
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_last_in  = 1'b1;
                  rsp_row_in   = '0;
                  rsp_col_in   = '0;
                  state_in     = ST_OUT_WAIT;
               end else begin
                  state_in = ST_BACK;
               end
            end else begin
               idx_in   = '0;
               rd_addr  = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            rd_addr = COL_W'(idx_ff + CNT_W'(1));
            if (conflict) begin
               cand_in  = cand_ff + CNT_W'(1);
               state_in = ST_TRY;
            end else if (idx_ff + CNT_W'(1) == row_ff) begin
               wr_en    = 1'b1;
               wr_addr  = COL_W'(row_ff);
               wr_data  = COL_W'(cand_ff);
               row_in   = row_ff + CNT_W'(1);
               cand_in  = '0;
               state_in = ST_TRY;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_BACK: begin
            cand_in  = CNT_W'(rd_data_ff) + CNT_W'(1);
            state_in = ST_TRY;
         end
         ST_OUT_RD: begin
            rd_addr  = COL_W'(out_row_ff);
            state_in = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b1;
            rsp_last_in  = (out_row_ff + CNT_W'(1) == n_ff);
            rsp_row_in   = row_ext[3:0];
            rsp_col_in   = col_ext[3:0];
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  out_row_in = out_row_ff + CNT_W'(1);
                  state_in   = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      cand_ff      <= cand_in;
      idx_ff       <= idx_in;
      out_row_ff   <= out_row_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   // Placement memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         placed_column_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= placed_column_ff[rd_addr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/nqb_checker.sv
// ----------------------------------------------------------------------------
// nqb_checker
// Port-level checks for the N-queens solver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nqb_checker
   import nqb_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tuser,
   input wire logic                   rsp_tlast,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready
);

   // A not-found beat is a lone beat with zero data.
   a_not_found_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("not-found beat without tlast or with nonzero data");

   // No new board is taken while a result is still on offer.
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while a response is pending");

   // The solver goes busy right after taking a board.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("solver ready again right after a request");

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response beat changed");

endmodule

bind n_queens_backtrack_solver nqb_checker u_nqb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
